// ===== hdl/vtyp_pkg.sv =====
// vtyp_pkg: shared types, constants and arctangent table for the
// vector to yaw/pitch converter. no dependencies.
`timescale 1ns / 1ps
package vtyp_pkg;

    localparam int COMP_W             = 24;
    localparam int ANGLE_FRAC_DEFAULT = 12;
    localparam int PRESCALE           = 54 - COMP_W;
    localparam int DATA_W             = 58;
    localparam int ACC_W              = 50;
    localparam int STEPS              = 32;
    localparam int DEG_STAGES         = 11;
    localparam int LATENCY            = 1 + 2 * STEPS + DEG_STAGES + 1;

    localparam logic [30:0] GAIN_Q30  = 31'd1768195363;
    localparam logic [63:0] DEG_UNIT  = 64'd1000000000000;
    localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(64'd180000000000000);

    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_270 = 9'd270;
    localparam logic [8:0] DEG_360 = 9'd360;

    // atan(2^-i) in units of 1e-12 degree
    localparam logic [ACC_W-2:0] ATAN_TABLE [STEPS] = '{
        49'd45000000000000, 49'd26565051177078, 49'd14036243467926, 49'd7125016348902,
        49'd3576334374997, 49'd1789910608246, 49'd895173710211, 49'd447614170861,
        49'd223810500369, 49'd111905677066, 49'd55952891894, 49'd27976452617,
        49'd13988227142, 49'd6994113675, 49'd3497056851, 49'd1748528427,
        49'd874264214, 49'd437132107, 49'd218566053, 49'd109283027,
        49'd54641513, 49'd27320757, 49'd13660378, 49'd6830189,
        49'd3415095, 49'd1707547, 49'd853774, 49'd426887,
        49'd213443, 49'd106722, 49'd53361, 49'd26680
    };

    typedef struct packed {
        logic signed [COMP_W-1:0] x_component;
        logic signed [COMP_W-1:0] y_component;
        logic signed [COMP_W-1:0] z_component;
    } cmd_t;

    typedef struct packed {
        logic signed [9:0] pitch_angle;
        logic [8:0]        yaw_angle;
    } result_t;

endpackage

// ===== hdl/vtyp_cell.sv =====
// vtyp_cell: one registered cordic vectoring step with a side payload.
// depends on vtyp_pkg.
`timescale 1ns / 1ps
module vtyp_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [vtyp_pkg::DATA_W-1:0] in_x,
    input  logic signed [vtyp_pkg::DATA_W-1:0] in_y,
    input  logic signed [vtyp_pkg::ACC_W-1:0]  in_acc,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic signed [vtyp_pkg::DATA_W-1:0] out_x,
    output logic signed [vtyp_pkg::DATA_W-1:0] out_y,
    output logic signed [vtyp_pkg::ACC_W-1:0]  out_acc,
    output logic [SIDE_W-1:0]                 out_side
);
    import vtyp_pkg::*;

    logic signed [DATA_W-1:0] dx, dy, x_next, y_next;
    logic signed [ACC_W-1:0]  angle, acc_next;
    logic                     valid_reg;
    logic signed [DATA_W-1:0] x_reg, y_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SIDE_W-1:0]        side_reg;

    always_comb
    begin
        dx    = in_y >>> STEP;
        dy    = in_x >>> STEP;
        angle = signed'({1'b0, ATAN_TABLE[STEP]});
        if (!in_y[DATA_W-1])
        begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            acc_next = in_acc + angle;
        end
        else
        begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            acc_next = in_acc - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_reg;
endmodule

// ===== hdl/vtyp_deg.sv =====
// vtyp_deg: pipelined conversion of an accumulated angle to whole degrees
// wrapped to 0..359 (abs stage, nine quotient cells, rounding stage). uses vtyp_pkg.
`timescale 1ns / 1ps
module vtyp_deg #(
    parameter int FRAC_BITS = vtyp_pkg::ANGLE_FRAC_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [vtyp_pkg::ACC_W-1:0] in_acc,
    output logic                             out_valid,
    output logic [8:0]                       out_deg
);
    import vtyp_pkg::*;

    localparam int QB = 9;
    localparam logic [63:0] ROUND_HALF = DEG_UNIT >> 1;
    localparam logic [63:0] ROUND_LIM  = DEG_UNIT << FRAC_BITS;

    logic                 v_reg   [QB+1];
    logic                 neg_reg [QB+1];
    logic [ACC_W-2:0]     rem_reg [QB+1];
    logic [QB-1:0]        quo_reg [QB+1];
    logic                 fv_reg;
    logic [8:0]           deg_reg;

    logic [ACC_W-1:0]     abs_val;
    logic                 round_up;
    logic [8:0]           ip, deg_next;

    assign abs_val = in_acc[ACC_W-1] ? ACC_W'(-in_acc) : ACC_W'(in_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= in_acc[ACC_W-1];
        rem_reg[0] <= abs_val[ACC_W-2:0];
        quo_reg[0] <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_div
            localparam logic [ACC_W-2:0] TH = (ACC_W-1)'(DEG_UNIT << (QB - 1 - k));
            logic hit;
            assign hit = rem_reg[k] >= TH;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k+1] <= 1'b0;
                else
                    v_reg[k+1] <= v_reg[k];
            end

            always_ff @(posedge clk)
            begin
                neg_reg[k+1] <= neg_reg[k];
                rem_reg[k+1] <= hit ? rem_reg[k] - TH : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (QB'(hit) << (QB - 1 - k));
            end
        end
    endgenerate

    // fraction rounds up onto the next integer degree; a negative angle wraps to 360 minus it
    always_comb
    begin
        round_up = ((64'(rem_reg[QB]) << FRAC_BITS) + ROUND_HALF) >= ROUND_LIM;
        ip       = quo_reg[QB] + 9'(round_up);
        if (neg_reg[QB] && ip != 9'd0)
            deg_next = DEG_360 - ip;
        else
            deg_next = ip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= v_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        deg_reg <= deg_next;
    end

    assign out_valid = fv_reg;
    assign out_deg   = deg_reg;
endmodule

// ===== hdl/vector_to_yaw_pitch_degrees_top.sv =====
// one word per cycle; every accepted start gives one done.
// the path is a prescale stage, 32 yaw cordic cells, 32 pitch cordic cells,
// an 11-stage degree converter and the output register; busy stays low.
// the receiver cannot stall; done pulses for one cycle per word.
// reset (rst_n low, async) empties the pipeline; no result is lost after it.
`timescale 1ns / 1ps
module vector_to_yaw_pitch_degrees_top #(
    parameter int ANGLE_FRACTION_BITS = vtyp_pkg::ANGLE_FRAC_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vtyp_pkg::cmd_t    cmd,
    output logic              done,
    output vtyp_pkg::result_t result
);
    import vtyp_pkg::*;

    localparam int PROD_W = COMP_W + 32;
    localparam int ZSHL   = (PRESCALE >= 30) ? PRESCALE - 30 : 0;
    localparam int ZSHR   = (PRESCALE < 30) ? 30 - PRESCALE : 0;
    localparam int YSIDE  = 2 + DATA_W;
    localparam int PSIDE  = 2 + ACC_W;

    // prescale stage
    logic                     s0_valid_reg;
    logic signed [DATA_W-1:0] s0_x_reg, s0_y_reg, s0_zk_reg;
    logic signed [ACC_W-1:0]  s0_base_reg;
    logic                     s0_special_reg, s0_zpos_reg;

    logic signed [DATA_W-1:0] sx, sy, zk;
    logic signed [PROD_W-1:0] prod;
    logic signed [63:0]       prod_ext;

    always_comb
    begin
        sx       = DATA_W'(cmd.x_component) <<< PRESCALE;
        sy       = DATA_W'(cmd.y_component) <<< PRESCALE;
        prod     = PROD_W'(cmd.z_component) * signed'({1'b0, GAIN_Q30});
        prod_ext = 64'(prod);
        zk       = DATA_W'((prod_ext <<< ZSHL) >>> ZSHR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_special_reg <= (cmd.x_component == '0) && (cmd.y_component == '0);
        s0_zpos_reg    <= !cmd.z_component[COMP_W-1] && (cmd.z_component != '0);
        s0_zk_reg      <= zk;
        // left half plane: turn by 180 degrees first
        if (cmd.x_component[COMP_W-1])
        begin
            s0_x_reg    <= -sx;
            s0_y_reg    <= -sy;
            s0_base_reg <= cmd.y_component[COMP_W-1] ? -signed'(HALF_TURN)
                                                     : signed'(HALF_TURN);
        end
        else
        begin
            s0_x_reg    <= sx;
            s0_y_reg    <= sy;
            s0_base_reg <= '0;
        end
    end

    // yaw chain
    logic                     yv   [STEPS+1];
    logic signed [DATA_W-1:0] yx   [STEPS+1];
    logic signed [DATA_W-1:0] yy   [STEPS+1];
    logic signed [ACC_W-1:0]  yacc [STEPS+1];
    logic [YSIDE-1:0]         ys   [STEPS+1];

    assign yv[0]   = s0_valid_reg;
    assign yx[0]   = s0_x_reg;
    assign yy[0]   = s0_y_reg;
    assign yacc[0] = s0_base_reg;
    assign ys[0]   = {s0_special_reg, s0_zpos_reg, s0_zk_reg};

    // pitch chain
    logic                     pv   [STEPS+1];
    logic signed [DATA_W-1:0] px   [STEPS+1];
    logic signed [DATA_W-1:0] py   [STEPS+1];
    logic signed [ACC_W-1:0]  pacc [STEPS+1];
    logic [PSIDE-1:0]         ps   [STEPS+1];

    assign pv[0]   = yv[STEPS];
    assign px[0]   = yx[STEPS];
    assign py[0]   = signed'(ys[STEPS][DATA_W-1:0]);
    assign pacc[0] = '0;
    assign ps[0]   = {ys[STEPS][YSIDE-1:YSIDE-2], yacc[STEPS]};

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_chain
            vtyp_cell #(.STEP(i), .SIDE_W(YSIDE)) u_yaw (
                .clk(clk), .rst_n(rst_n),
                .in_valid(yv[i]), .in_x(yx[i]), .in_y(yy[i]),
                .in_acc(yacc[i]), .in_side(ys[i]),
                .out_valid(yv[i+1]), .out_x(yx[i+1]), .out_y(yy[i+1]),
                .out_acc(yacc[i+1]), .out_side(ys[i+1])
            );
            vtyp_cell #(.STEP(i), .SIDE_W(PSIDE)) u_pitch (
                .clk(clk), .rst_n(rst_n),
                .in_valid(pv[i]), .in_x(px[i]), .in_y(py[i]),
                .in_acc(pacc[i]), .in_side(ps[i]),
                .out_valid(pv[i+1]), .out_x(px[i+1]), .out_y(py[i+1]),
                .out_acc(pacc[i+1]), .out_side(ps[i+1])
            );
        end
    endgenerate

    // degree conversion, yaw and pitch side by side
    logic       yd_valid, pd_valid;
    logic [8:0] yaw_deg, pitch_deg;

    vtyp_deg #(.FRAC_BITS(ANGLE_FRACTION_BITS)) u_yaw_deg (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pv[STEPS]), .in_acc(signed'(ps[STEPS][ACC_W-1:0])),
        .out_valid(yd_valid), .out_deg(yaw_deg)
    );

    vtyp_deg #(.FRAC_BITS(ANGLE_FRACTION_BITS)) u_pitch_deg (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pv[STEPS]), .in_acc(pacc[STEPS]),
        .out_valid(pd_valid), .out_deg(pitch_deg)
    );

    // vertical-vector flags ride alongside the converter
    logic [1:0] flag_reg [DEG_STAGES];

    always_ff @(posedge clk)
    begin
        flag_reg[0] <= ps[STEPS][PSIDE-1:PSIDE-2];
        for (int k = 1; k < DEG_STAGES; k++)
            flag_reg[k] <= flag_reg[k-1];
    end

    logic       done_reg;
    result_t    result_reg;
    logic [8:0] yaw_fin, pitch_fin;

    always_comb
    begin
        if (flag_reg[DEG_STAGES-1][1])
        begin
            yaw_fin   = '0;
            pitch_fin = flag_reg[DEG_STAGES-1][0] ? DEG_90 : DEG_270;
        end
        else
        begin
            yaw_fin   = yaw_deg;
            pitch_fin = pitch_deg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= yd_valid && pd_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg.yaw_angle   <= yaw_fin;
        result_reg.pitch_angle <= -signed'({1'b0, pitch_fin});
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;
endmodule

// ===== hdl/vtyp_check.sv =====
// vtyp_check: port-level assertions for the converter top, bound in below.
// depends on vtyp_pkg and vector_to_yaw_pitch_degrees_top.
`timescale 1ns / 1ps
module vtyp_check (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input vtyp_pkg::cmd_t    cmd,
    input logic              done,
    input vtyp_pkg::result_t result
);
    import vtyp_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // samples from before reset settles may be unknown; only a known accept counts
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == ($past(start && !busy, LATENCY) === 1'b1))
        else $error("done does not match accepted word");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.yaw_angle < 9'd360)
        else $error("yaw out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.pitch_angle <= 10'sd0 && result.pitch_angle >= -10'sd359))
        else $error("pitch out of range");

    a_vertical: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd.x_component == '0 && cmd.y_component == '0, LATENCY))
        |-> (result.yaw_angle == '0 &&
             (result.pitch_angle == -10'sd90 || result.pitch_angle == -10'sd270)))
        else $error("vertical vector result wrong");
endmodule

bind vector_to_yaw_pitch_degrees_top vtyp_check u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
);

// ===== sim/vector_to_yaw_pitch_degrees_top_tb.sv =====
// vector_to_yaw_pitch_degrees_top_tb: self-checking bench for the direction to yaw/pitch block.
// needs vtyp_pkg and vector_to_yaw_pitch_degrees_top; predicts each word with its own cordic.
`timescale 1ns / 1ps
module vector_to_yaw_pitch_degrees_top_tb;
    import vtyp_pkg::*;

    localparam longint DEG_ONE = 64'sd1000000000000;
    localparam longint GAIN    = 64'sd1768195363;
    localparam int     FRAC    = 12;
    localparam int     PRE     = 30;
    localparam int     N_RAND  = 1030;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    cmd_t    vectors_waiting[$];
    result_t angles_expected[$];
    int      send_idle_pct;
    logic    hold_send;
    int      sent_count;
    int      fail_count;

    vector_to_yaw_pitch_degrees_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .done(done), .result(result)
    );

    const longint arctan_deg[32] = '{
        64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926, 64'sd7125016348902,
        64'sd3576334374997, 64'sd1789910608246, 64'sd895173710211, 64'sd447614170861,
        64'sd223810500369, 64'sd111905677066, 64'sd55952891894, 64'sd27976452617,
        64'sd13988227142, 64'sd6994113675, 64'sd3497056851, 64'sd1748528427,
        64'sd874264214, 64'sd437132107, 64'sd218566053, 64'sd109283027,
        64'sd54641513, 64'sd27320757, 64'sd13660378, 64'sd6830189,
        64'sd3415095, 64'sd1707547, 64'sd853774, 64'sd426887,
        64'sd213443, 64'sd106722, 64'sd53361, 64'sd26680
    };

    // rotate (a, b) onto the positive a axis, return the swept angle
    function automatic longint vector_rotate(inout longint a, inout longint b);
        longint acc;
        longint da;
        longint db;
        acc = 0;
        for (int i = 0; i < 32; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a = a + da; b = b - db; acc = acc + arctan_deg[i];
            end
            else
            begin
                a = a - da; b = b + db; acc = acc - arctan_deg[i];
            end
        end
        return acc;
    endfunction

    // round at FRAC bits of a degree, then truncate toward zero, wrap to 0..359
    function automatic longint to_whole_degrees(longint acc);
        longint mag;
        longint ip;
        longint fr;
        longint q;
        mag = (acc < 0) ? -acc : acc;
        ip  = mag / DEG_ONE;
        fr  = mag % DEG_ONE;
        q   = ((fr <<< FRAC) + DEG_ONE / 2) / DEG_ONE;
        if ((q >>> FRAC) != 0)
            ip++;
        if (acc < 0)
            ip = 360 - ip;
        if (ip == 360)
            ip = 0;
        return ip;
    endfunction

    function automatic result_t predict_angles(cmd_t c);
        longint  x;
        longint  y;
        longint  z;
        longint  sx;
        longint  sy;
        longint  zk;
        longint  base;
        longint  yaw;
        longint  pitch;
        result_t r;
        x = longint'(c.x_component);
        y = longint'(c.y_component);
        z = longint'(c.z_component);
        if (x == 0 && y == 0)
        begin
            yaw   = 0;
            pitch = (z > 0) ? 90 : 270;
        end
        else
        begin
            sx   = x <<< PRE;
            sy   = y <<< PRE;
            base = 0;
            if (sx < 0)
            begin
                sx   = -sx;
                sy   = -sy;
                base = (y >= 0) ? 180 * DEG_ONE : -180 * DEG_ONE;
            end
            yaw   = to_whole_degrees(base + vector_rotate(sx, sy));
            zk    = z * GAIN;
            pitch = to_whole_degrees(vector_rotate(sx, zk));
        end
        r.pitch_angle = 10'(-pitch);
        r.yaw_angle   = 9'(yaw);
        return r;
    endfunction

    function automatic cmd_t make_vector(int x, int y, int z);
        cmd_t c;
        c.x_component = 24'(x);
        c.y_component = 24'(y);
        c.z_component = 24'(z);
        return c;
    endfunction

    function automatic logic [23:0] rand_component(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($urandom_range(32) - 16);
            2: return 24'(0);
            default: return ($urandom_range(1)) ? 24'h800000 : 24'h7fffff;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver: one word per accepted start
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= '0;
            sent_count <= 0;
        end
        else
        begin
            logic go;
            if (start && !busy)
            begin
                angles_expected.push_back(predict_angles(cmd));
                void'(vectors_waiting.pop_front());
                sent_count <= sent_count + 1;
            end
            go = (vectors_waiting.size() != 0) && !hold_send &&
                 ($urandom_range(99) >= send_idle_pct);
            start <= go;
            if (go)
                cmd <= vectors_waiting[0];
        end
    end

    // monitor: results cannot be held off, check each one as it appears
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (angles_expected.size() == 0)
            begin
                $display("%0t: unexpected word pitch=%0d yaw=%0d", $time,
                         result.pitch_angle, result.yaw_angle);
                fail_count++;
            end
            else
            begin
                result_t e;
                e = angles_expected.pop_front();
                if (e.pitch_angle !== result.pitch_angle)
                begin
                    $display("%0t: pitch_angle expected %0d actual %0d", $time,
                             e.pitch_angle, result.pitch_angle);
                    fail_count++;
                end
                if (e.yaw_angle !== result.yaw_angle)
                begin
                    $display("%0t: yaw_angle expected %0d actual %0d", $time,
                             e.yaw_angle, result.yaw_angle);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int m;
        rst_n         = 1'b0;
        hold_send     = 1'b0;
        send_idle_pct = 35;
        fail_count    = 0;
        // vertical vectors, axes, extremes, x<0 with y==0, exact diagonals
        vectors_waiting.push_back(make_vector(0, 0, 0));
        vectors_waiting.push_back(make_vector(0, 0, 5));
        vectors_waiting.push_back(make_vector(0, 0, -5));
        vectors_waiting.push_back(make_vector(0, 0, 8388607));
        vectors_waiting.push_back(make_vector(0, 0, -8388608));
        vectors_waiting.push_back(make_vector(1, 0, 0));
        vectors_waiting.push_back(make_vector(-1, 0, 0));
        vectors_waiting.push_back(make_vector(-7, 0, 3));
        vectors_waiting.push_back(make_vector(0, 1, 0));
        vectors_waiting.push_back(make_vector(0, -1, 0));
        vectors_waiting.push_back(make_vector(1, 1, 0));
        vectors_waiting.push_back(make_vector(-1, -1, 0));
        vectors_waiting.push_back(make_vector(1, -1, 1));
        vectors_waiting.push_back(make_vector(-1, 1, -1));
        vectors_waiting.push_back(make_vector(8388607, 8388607, 8388607));
        vectors_waiting.push_back(make_vector(-8388608, -8388608, -8388608));
        vectors_waiting.push_back(make_vector(-8388608, 8388607, 0));
        vectors_waiting.push_back(make_vector(8388607, -8388608, -8388608));
        vectors_waiting.push_back(make_vector(1, 0, 8388607));
        vectors_waiting.push_back(make_vector(-8388608, 0, -1));
        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        // let the directed words drain completely before going on
        wait (vectors_waiting.size() == 0);
        @(negedge clk);
        hold_send = 1'b1;
        while (angles_expected.size() != 0 || start)
            @(negedge clk);
        hold_send = 1'b0;

        for (int i = 0; i < N_RAND; i++)
        begin
            cmd_t c;
            m = $urandom_range(9);
            m = (m < 6) ? 0 : (m < 8) ? 1 : (m == 8) ? 2 : 3;
            c.x_component = rand_component(m);
            c.y_component = rand_component(m == 2 ? 2 : $urandom_range(1) ? m : 0);
            c.z_component = rand_component($urandom_range(3));
            vectors_waiting.push_back(c);
        end
        while (sent_count < 20 + N_RAND / 3)
            @(negedge clk);
        send_idle_pct = 53;
        while (sent_count < 20 + 2 * N_RAND / 3)
            @(negedge clk);
        send_idle_pct = 0;

        while (vectors_waiting.size() != 0 || start || angles_expected.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/vtyp_pkg.sv
hdl/vtyp_cell.sv
hdl/vtyp_deg.sv
hdl/vector_to_yaw_pitch_degrees_top.sv
hdl/vtyp_check.sv
sim/vector_to_yaw_pitch_degrees_top_tb.sv
